### hw/rtl/delimited_sentence_position_parser_macros.svh
// Assertion shorthands shared by the parser blocks.
// Both sample on the rising edge of clk and are disabled while rst is high.
`ifndef DELIMITED_SENTENCE_POSITION_PARSER_MACROS_SVH
`define DELIMITED_SENTENCE_POSITION_PARSER_MACROS_SVH

// Same-cycle implication.
`define DSPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DSPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/dspp_pkg.sv
`default_nettype none

package dspp_pkg;

  // Default sizing
  localparam int DSPP_FRAME_BYTES      = 74;
  localparam int DSPP_FRACTION_DIGITS  = 6;
  localparam int DSPP_VALUE_BITS       = 48;

  // Fraction digit count and scale exponent (fraction digits never exceed 7)
  localparam int FRAC_CNT_W = 3;
  // Width of the largest power of ten used for scaling (10^7)
  localparam int POW_W      = 24;

  // One beat from the parser to the value path
  typedef struct packed {
    logic                  open;     // frame opened: reload working values
    logic                  close;    // frame closed: commit and show result
    logic                  store;    // token value goes to a slot
    logic [1:0]            slot;     // 0 latitude, 1 longitude, 2 altitude
    logic                  neg;      // value sign
    logic [FRAC_CNT_W-1:0] nshift;   // missing fraction digits to scale in
    logic [2:0]            written;  // slots assigned in this frame
    logic [1:0]            mode;     // mode after the frame
  } dspp_event_t;

  // 10^n for the scale step
  function automatic logic [POW_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] n);
    logic [POW_W-1:0] p;
    case (n)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      3'd7:    p = 24'd10000000;
      default: p = 24'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/dspp_parser.sv
`default_nettype none
`include "delimited_sentence_position_parser_macros.svh"

module dspp_parser
  import dspp_pkg::*;
#(
  parameter int FRAME_BYTES     = DSPP_FRAME_BYTES,
  parameter int FRACTION_DIGITS = DSPP_FRACTION_DIGITS,
  parameter int VALUE_BITS      = DSPP_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  take,
  input  wire logic [7:0]            rx_byte,
  output dspp_event_t                ev,
  output logic      [VALUE_BITS-1:0] ev_mag
);

  localparam int KW = $clog2(FRAME_BYTES);
  localparam logic [KW-1:0] KEEP_MAX = KW'(FRAME_BYTES - 1);
  localparam logic [FRAC_CNT_W-1:0] FRAC_N = FRAC_CNT_W'(FRACTION_DIGITS);
  localparam logic [VALUE_BITS-1:0] LIM = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_OPEN  = 8'h3C;
  localparam logic [7:0] CH_CLOSE = 8'h3E;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_O     = 8'h4F;

  // Header match progress
  localparam logic [3:0] HDR_PREFIX = 4'd5;
  localparam logic [3:0] HDR_MODE1  = 4'd6;
  localparam logic [3:0] HDR_MODE2  = 4'd7;
  localparam logic [3:0] HDR_FAIL   = 4'd15;

  // Number scan phases
  localparam logic [2:0] PH_LEAD = 3'd0;
  localparam logic [2:0] PH_SIGN = 3'd1;
  localparam logic [2:0] PH_INT  = 3'd2;
  localparam logic [2:0] PH_FRAC = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  // Sentence modes
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_POS   = 2'd1;
  localparam logic [1:0] MODE_OTHER = 2'd2;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = CH_DOLLAR;
      3'd1:    ch = CH_O;
      3'd2:    ch = CH_A;
      default: ch = CH_ZERO;
    endcase
    return ch;
  endfunction

  logic                  in_valid_q;
  logic [7:0]            byte_q;
  logic                  in_frame, in_frame_next;
  logic [KW-1:0]         kept, kept_next;
  logic                  text_ended, text_ended_next;
  logic [5:0]            token_number, token_number_next;
  logic                  token_nonempty, token_nonempty_next;
  logic [3:0]            header_progress, header_progress_next;
  logic [2:0]            number_phase, number_phase_next;
  logic                  number_negative, number_negative_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic [FRAC_CNT_W-1:0] frac_cnt, frac_cnt_next;
  logic [1:0]            working_mode, working_mode_next;
  logic [1:0]            committed_mode, committed_mode_next;
  logic [2:0]            pending_written, pending_written_next;
  dspp_event_t           ev_next;

  logic                  tok_done, tok_feed, closing, take_int;
  logic                  is_digit, is_space;
  logic [3:0]            dig;
  logic [VALUE_BITS+3:0] ext, mac_full;
  logic [VALUE_BITS-1:0] mac;

  // Decode the held byte and form the saturating multiply-add
  always_comb begin
    is_digit = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
    is_space = (byte_q == CH_SPACE) || ((byte_q >= CH_TAB) && (byte_q <= CH_CR));
    dig      = 4'(byte_q - CH_ZERO);
    ext      = {4'b0000, acc};
    mac_full = (ext << 3) + (ext << 1) + {{VALUE_BITS{1'b0}}, dig};
    mac      = (mac_full > {4'b0000, LIM}) ? LIM : mac_full[VALUE_BITS-1:0];
  end

  // Next state for one byte
  always_comb begin
    in_frame_next        = in_frame;
    kept_next            = kept;
    text_ended_next      = text_ended;
    token_number_next    = token_number;
    token_nonempty_next  = token_nonempty;
    header_progress_next = header_progress;
    number_phase_next    = number_phase;
    number_negative_next = number_negative;
    acc_next             = acc;
    frac_cnt_next        = frac_cnt;
    working_mode_next    = working_mode;
    committed_mode_next  = committed_mode;
    pending_written_next = pending_written;
    ev_next              = '0;
    tok_done             = 1'b0;
    tok_feed             = 1'b0;
    closing              = 1'b0;
    take_int             = 1'b0;

    // Frame framing and byte keeping
    if (in_valid_q) begin
      if (!in_frame) begin
        if (byte_q == CH_OPEN) begin
          in_frame_next        = 1'b1;
          kept_next            = '0;
          text_ended_next      = 1'b0;
          token_number_next    = '0;
          token_nonempty_next  = 1'b0;
          header_progress_next = '0;
          number_phase_next    = PH_LEAD;
          number_negative_next = 1'b0;
          acc_next             = '0;
          frac_cnt_next        = '0;
          working_mode_next    = committed_mode;
          pending_written_next = '0;
          ev_next.open         = 1'b1;
        end
      end else if (byte_q != CH_CLOSE) begin
        if (kept < KEEP_MAX) begin
          kept_next = kept + 1'b1;
          if (!text_ended) begin
            if (byte_q == CH_NUL) begin
              tok_done        = 1'b1;
              text_ended_next = 1'b1;
            end else if (byte_q == CH_COMMA) begin
              tok_done = 1'b1;
            end else begin
              tok_feed = 1'b1;
            end
          end
        end
      end else begin
        tok_done = 1'b1;
        closing  = 1'b1;
      end
    end

    // Feed one character into the current token
    if (tok_feed) begin
      token_nonempty_next = 1'b1;
      if (header_progress < HDR_PREFIX) begin
        header_progress_next = (byte_q == hdr_char(header_progress[2:0])) ?
                               header_progress + 1'b1 : HDR_FAIL;
      end else if (header_progress == HDR_PREFIX) begin
        header_progress_next = (byte_q == CH_EIGHT) ? HDR_MODE1 :
                               (byte_q == CH_NINE)  ? HDR_MODE2 : HDR_FAIL;
      end else begin
        header_progress_next = HDR_FAIL;
      end

      case (number_phase)
        PH_LEAD: begin
          if (is_space) begin
            number_phase_next = PH_LEAD;
          end else if ((byte_q == CH_PLUS) || (byte_q == CH_MINUS)) begin
            number_negative_next = (byte_q == CH_MINUS);
            number_phase_next    = PH_SIGN;
          end else begin
            take_int = 1'b1;
          end
        end
        PH_SIGN, PH_INT: begin
          take_int = 1'b1;
        end
        PH_FRAC: begin
          if (is_digit) begin
            if (frac_cnt < FRAC_N) begin
              acc_next      = mac;
              frac_cnt_next = frac_cnt + 1'b1;
            end
          end else begin
            number_phase_next = PH_DONE;
          end
        end
        default: begin
          number_phase_next = number_phase;
        end
      endcase

      if (take_int) begin
        if (is_digit) begin
          acc_next          = mac;
          number_phase_next = PH_INT;
        end else if (byte_q == CH_DOT) begin
          number_phase_next = PH_FRAC;
        end else begin
          number_phase_next = PH_DONE;
        end
      end
    end

    // Finish a nonempty token: mode select, slot store, advance count
    if (tok_done && token_nonempty) begin
      if (header_progress == HDR_MODE1) begin
        working_mode_next = MODE_POS;
      end else if (header_progress == HDR_MODE2) begin
        working_mode_next = MODE_OTHER;
      end
      if (working_mode_next == MODE_POS) begin
        if ((token_number >= 6'd1) && (token_number <= 6'd3)) begin
          ev_next.store        = 1'b1;
          ev_next.slot         = 2'(token_number - 6'd1);
          ev_next.neg          = number_negative;
          ev_next.nshift       = FRAC_N - frac_cnt;
          pending_written_next = pending_written | (3'b001 << ev_next.slot);
        end else if (token_number == 6'd4) begin
          working_mode_next = MODE_NONE;
        end
      end
      if (token_number != 6'd63) begin
        token_number_next = token_number + 1'b1;
      end
      token_nonempty_next  = 1'b0;
      header_progress_next = '0;
      number_phase_next    = PH_LEAD;
      number_negative_next = 1'b0;
      acc_next             = '0;
      frac_cnt_next        = '0;
    end

    // Close the frame
    if (closing) begin
      in_frame_next       = 1'b0;
      kept_next           = '0;
      text_ended_next     = 1'b0;
      token_number_next   = '0;
      committed_mode_next = working_mode_next;
      ev_next.close       = 1'b1;
      ev_next.written     = pending_written_next;
      ev_next.mode        = working_mode_next;
    end
  end

  // Hold the input beat and the parse state; advance when the path moves
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q      <= 1'b0;
      in_frame        <= 1'b0;
      kept            <= '0;
      text_ended      <= 1'b0;
      token_number    <= '0;
      token_nonempty  <= 1'b0;
      header_progress <= '0;
      number_phase    <= PH_LEAD;
      number_negative <= 1'b0;
      acc             <= '0;
      frac_cnt        <= '0;
      working_mode    <= MODE_NONE;
      committed_mode  <= MODE_NONE;
      pending_written <= '0;
      ev              <= '0;
    end else if (en) begin
      in_valid_q      <= take;
      in_frame        <= in_frame_next;
      kept            <= kept_next;
      text_ended      <= text_ended_next;
      token_number    <= token_number_next;
      token_nonempty  <= token_nonempty_next;
      header_progress <= header_progress_next;
      number_phase    <= number_phase_next;
      number_negative <= number_negative_next;
      acc             <= acc_next;
      frac_cnt        <= frac_cnt_next;
      working_mode    <= working_mode_next;
      committed_mode  <= committed_mode_next;
      pending_written <= pending_written_next;
      ev              <= ev_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      byte_q <= rx_byte;
    end
    if (en) begin
      ev_mag <= acc;
    end
  end

  `DSPP_ASSERT_NOW(a_text_in_frame, text_ended, in_frame, "text end flag outside a frame")
  `DSPP_ASSERT_NOW(a_kept_bound, 1'b1, kept <= KEEP_MAX, "kept byte count past frame size")
  `DSPP_ASSERT_NOW(a_open_alone, ev.open, !ev.store && !ev.close, "open beat mixed with others")

endmodule

`default_nettype wire

### hw/rtl/dspp_scale.sv
`default_nettype none

module dspp_scale
  import dspp_pkg::*;
#(
  parameter int VALUE_BITS = DSPP_VALUE_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire dspp_event_t                        ev,
  input  wire logic [VALUE_BITS-1:0]              ev_mag,
  output dspp_event_t                             ctl,
  output logic [(VALUE_BITS+1)/2+POW_W-1:0]       lo,
  output logic [VALUE_BITS-(VALUE_BITS+1)/2+POW_W-1:0] hi
);

  localparam int HALF = (VALUE_BITS + 1) / 2;
  localparam int LO_W = HALF + POW_W;
  localparam int HI_W = VALUE_BITS - HALF + POW_W;

  logic [POW_W-1:0] p;

  // Pick the power of ten for the missing fraction digits
  assign p = pow10(ev.nshift);

  // Hold the control beat
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ev;
    end
  end

  // Form the two partial products of magnitude times 10^n
  always_ff @(posedge clk) begin
    if (en) begin
      lo <= LO_W'(ev_mag[HALF-1:0]) * LO_W'(p);
      hi <= HI_W'(ev_mag[VALUE_BITS-1:HALF]) * HI_W'(p);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dspp_store.sv
`default_nettype none
`include "delimited_sentence_position_parser_macros.svh"

module dspp_store
  import dspp_pkg::*;
#(
  parameter int VALUE_BITS = DSPP_VALUE_BITS
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    en,
  input  wire dspp_event_t                             ctl,
  input  wire logic [(VALUE_BITS+1)/2+POW_W-1:0]       lo,
  input  wire logic [VALUE_BITS-(VALUE_BITS+1)/2+POW_W-1:0] hi,
  output logic                                         hold,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [VALUE_BITS-1:0]                 latitude,
  output logic signed [VALUE_BITS-1:0]                 longitude,
  output logic signed [VALUE_BITS-1:0]                 altitude,
  output logic                                         latitude_written,
  output logic                                         longitude_written,
  output logic                                         altitude_written,
  output logic [1:0]                                   sentence_mode
);

  localparam int HALF  = (VALUE_BITS + 1) / 2;
  localparam int SUM_W = VALUE_BITS + POW_W;
  localparam int RES_W = 3 * VALUE_BITS + 5;
  localparam logic [VALUE_BITS-1:0] LIM    = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] MAXPOS = {1'b0, {(VALUE_BITS-1){1'b1}}};

  logic [SUM_W-1:0]      sum;
  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] pending   [3];
  logic [VALUE_BITS-1:0] committed [3];
  logic [VALUE_BITS-1:0] pend_new  [3];
  logic [RES_W-1:0]      res_new;
  logic [RES_W-1:0]      res_out;
  logic [RES_W-1:0]      res_skid;
  logic                  skid_valid;
  logic                  out_free;

  // Join partial products, saturate, apply sign
  always_comb begin
    sum   = (SUM_W'(hi) << HALF) + SUM_W'(lo);
    mag   = (sum > SUM_W'(LIM)) ? LIM : sum[VALUE_BITS-1:0];
    value = ctl.neg ? (~mag + 1'b1) : (mag[VALUE_BITS-1] ? MAXPOS : mag);
    for (int i = 0; i < 3; i++) begin
      pend_new[i] = (ctl.store && (ctl.slot == 2'(i))) ? value : pending[i];
    end
    res_new = {pend_new[0], pend_new[1], pend_new[2], ctl.written, ctl.mode};
  end

  // Working and committed values
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pending[i]   <= '0;
        committed[i] <= '0;
      end
    end else if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (ctl.open) begin
          pending[i] <= committed[i];
        end else begin
          pending[i] <= pend_new[i];
        end
        if (ctl.close) begin
          committed[i] <= pend_new[i];
        end
      end
    end
  end

  // Output slot frees when empty or taken; a result that finds it busy
  // waits in the spare register, and the path holds while that is full
  assign out_free = !out_valid || !out_stall;
  assign hold     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || (en && ctl.close);
      skid_valid <= 1'b0;
    end else if (en && ctl.close) begin
      skid_valid <= 1'b1;
    end
  end

  // Load the shown result, oldest first
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        res_out <= res_skid;
      end else if (en && ctl.close) begin
        res_out <= res_new;
      end
    end else if (en && ctl.close) begin
      res_skid <= res_new;
    end
  end

  assign latitude          = res_out[RES_W-1 -: VALUE_BITS];
  assign longitude         = res_out[RES_W-1-VALUE_BITS -: VALUE_BITS];
  assign altitude          = res_out[RES_W-1-2*VALUE_BITS -: VALUE_BITS];
  assign altitude_written  = res_out[4];
  assign longitude_written = res_out[3];
  assign latitude_written  = res_out[2];
  assign sentence_mode     = res_out[1:0];

  `DSPP_ASSERT_NEXT(a_close_shows, en && ctl.close, out_valid, "frame close lost its beat")
  `DSPP_ASSERT_NEXT(a_pos_store, en && ctl.store && !ctl.neg, !pending[$past(ctl.slot)][VALUE_BITS-1], "positive value stored negative")
  `DSPP_ASSERT_NOW(a_skid_behind, skid_valid, out_valid, "waiting result with nothing shown")

endmodule

`default_nettype wire

### hw/rtl/delimited_sentence_position_parser.sv
// Delimited sentence position parser.
// Input channel: in_valid / in_stall carry one received byte (rx_byte) per beat.
// Output channel: out_valid / out_stall carry one result per frame closed by '>':
//   latitude, longitude, altitude (signed millionths), their written flags and
//   sentence_mode after the frame.
// Throughput: one byte per cycle while in_stall is low. The byte is
//   registered, parsed by one step of a multiply-by-ten and compare, scaled
//   by a split constant multiply, then saturated and stored.
// Path: once the '>' beat is accepted, the result passes the held byte, the
//   parser event, the scale registers and then the output register when free.
// Stall: a result held by out_stall does not stop the path; a second result
//   waits in a spare register, and only then does the whole path hold and
//   in_stall rise (in_stall comes straight from that register). A shown
//   result is never dropped or altered.
// Reset: rst (synchronous, active high) clears framing, mode and all stored
//   values to zero and empties the path; no clearing pass is needed.
`default_nettype none

module delimited_sentence_position_parser
  import dspp_pkg::*;
#(
  parameter int FRAME_BYTES     = DSPP_FRAME_BYTES,
  parameter int FRACTION_DIGITS = DSPP_FRACTION_DIGITS,
  parameter int VALUE_BITS      = DSPP_VALUE_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   rx_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [VALUE_BITS-1:0]      latitude,
  output logic signed [VALUE_BITS-1:0]      longitude,
  output logic signed [VALUE_BITS-1:0]      altitude,
  output logic                              latitude_written,
  output logic                              longitude_written,
  output logic                              altitude_written,
  output logic [1:0]                        sentence_mode
);

  localparam int HALF = (VALUE_BITS + 1) / 2;

  logic                              en;
  logic                              hold;
  logic                              take;
  dspp_event_t                       ev;
  dspp_event_t                       ctl;
  logic [VALUE_BITS-1:0]             ev_mag;
  logic [HALF+POW_W-1:0]             lo;
  logic [VALUE_BITS-HALF+POW_W-1:0]  hi;

  // Advance the path unless a second result is waiting
  assign en       = !hold;
  assign in_stall = !en;
  assign take     = in_valid && en;

  dspp_parser #(
    .FRAME_BYTES     (FRAME_BYTES),
    .FRACTION_DIGITS (FRACTION_DIGITS),
    .VALUE_BITS      (VALUE_BITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .take    (take),
    .rx_byte (rx_byte),
    .ev      (ev),
    .ev_mag  (ev_mag)
  );

  dspp_scale #(
    .VALUE_BITS (VALUE_BITS)
  ) u_scale (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .ev     (ev),
    .ev_mag (ev_mag),
    .ctl    (ctl),
    .lo     (lo),
    .hi     (hi)
  );

  dspp_store #(
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk               (clk),
    .rst               (rst),
    .en                (en),
    .ctl               (ctl),
    .lo                (lo),
    .hi                (hi),
    .hold              (hold),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .latitude          (latitude),
    .longitude         (longitude),
    .altitude          (altitude),
    .latitude_written  (latitude_written),
    .longitude_written (longitude_written),
    .altitude_written  (altitude_written),
    .sentence_mode     (sentence_mode)
  );

endmodule

`default_nettype wire
